// ===== rtl/core/mbrc_pkg.sv =====
// Shared constants, command/status types and the CRC-16 byte update for the reply checker.
package mbrc_pkg;

   localparam int MAX_REGISTERS_DEF = 12;
   localparam int CNT_W             = 4;
   localparam int CFG_W             = 8;
   localparam int CSR_IDX_W         = 1;
   localparam int HDR_LEN           = 5;

   localparam int REQ_DATA_W = 8;
   localparam int IDX_OUT_W  = 4;
   localparam int VAL_W      = 16;
   localparam int STATUS_W   = 2;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_PAD_W  = RSP_DATA_W - IDX_OUT_W - VAL_W - STATUS_W;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] FUNC_READ_INPUT = 8'h04;
   localparam logic [7:0] FUNC_EXC_BIT    = 8'h80;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CRC     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_HDR     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_TIMEOUT = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SLAVE_ADDRESS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGISTER_COUNT = 1'b1;

   localparam logic [CFG_W-1:0] SLAVE_ADDRESS_RST  = 8'd1;
   localparam logic [CNT_W-1:0] REGISTER_COUNT_RST = 4'd1;

   typedef struct packed {
      logic take_byte;
      logic take_timeout;
      logic rd_next;
      logic emit_value;
      logic emit_status;
   } mbrc_cmd_type;

   typedef struct packed {
      logic final_byte;
      logic verdict_ok;
      logic rd_last;
      logic out_free;
   } mbrc_stat_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_i, input logic [7:0] b);
      logic [15:0] c;
      c = crc_i ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/mbrc_dp.sv =====
// Datapath: config registers, frame state, CRC, register buffer and result register.
module mbrc_dp
   import mbrc_pkg::*;
#(
   parameter int MAX_REGISTERS = MAX_REGISTERS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  mbrc_cmd_type          cmd,
   output mbrc_stat_type         stat,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int CNT_MAX    = (1 << CNT_W) - 1;
   localparam int BUF_DEPTH  = (MAX_REGISTERS < CNT_MAX) ? MAX_REGISTERS : CNT_MAX;
   localparam int LEN_MAX    = HDR_LEN + 2 * BUF_DEPTH;
   localparam int POS_W      = $clog2(LEN_MAX);
   localparam int IDX_W      = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int DATA_START = HDR_LEN - 2;

   localparam logic [POS_W-1:0] POS_ADDR  = POS_W'(0);
   localparam logic [POS_W-1:0] POS_FUNC  = POS_W'(1);
   localparam logic [POS_W-1:0] POS_COUNT = POS_W'(2);

   logic [CFG_W-1:0]  slave_addr_ff, slave_addr_in;
   logic [CNT_W-1:0]  reg_count_ff, reg_count_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [15:0]       crc_ff, crc_in;
   logic [7:0]        addr_ff, addr_in;
   logic [7:0]        func_ff, func_in;
   logic [7:0]        cnt_ff, cnt_in;
   logic [7:0]        crc_lo_ff, crc_lo_in;
   logic [STATUS_W-1:0] code_ff, code_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;

   logic [7:0]        buf_hi_ff [BUF_DEPTH];
   logic [7:0]        buf_lo_ff [BUF_DEPTH];
   logic [7:0]        rd_hi_ff;
   logic [7:0]        rd_lo_ff;

   logic                 out_valid_ff, out_valid_in;
   logic                 out_is_status_ff, out_is_status_in;
   logic [IDX_OUT_W-1:0] out_idx_ff, out_idx_in;
   logic [VAL_W-1:0]     out_val_ff, out_val_in;
   logic [STATUS_W-1:0]  out_status_ff, out_status_in;
   logic                 out_last_ff, out_last_in;

   logic [CNT_W-1:0]    n_eff;
   logic [POS_W-1:0]    len_m2;
   logic [POS_W-1:0]    off;
   logic [POS_W-1:0]    slot;
   logic                slot_ok;
   logic [STATUS_W-1:0] verdict;
   logic                hi_we;
   logic                lo_we;
   logic [7:0]          rx;

   assign rx = req_tdata;

   always_comb begin
      if (reg_count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (int'(reg_count_ff) > BUF_DEPTH) begin
         n_eff = CNT_W'(BUF_DEPTH);
      end else begin
         n_eff = reg_count_ff;
      end
   end

   assign len_m2  = POS_W'(DATA_START) + POS_W'({n_eff, 1'b0});
   assign off     = pos_ff - POS_W'(DATA_START);
   assign slot    = off >> 1;
   assign slot_ok = (pos_ff >= POS_W'(DATA_START)) && (slot < POS_W'(BUF_DEPTH));

   always_comb begin
      if (crc_ff != {rx, crc_lo_ff}) begin
         verdict = STATUS_CRC;
      end else if (((func_ff & FUNC_EXC_BIT) != 8'h00) || (addr_ff != slave_addr_ff) ||
                   (func_ff != FUNC_READ_INPUT) || (cnt_ff != 8'({n_eff, 1'b0}))) begin
         verdict = STATUS_HDR;
      end else begin
         verdict = STATUS_OK;
      end
   end

   assign stat.final_byte = pos_ff > len_m2;
   assign stat.verdict_ok = verdict == STATUS_OK;
   assign stat.rd_last    = CNT_W'(rd_idx_ff) == (n_eff - CNT_W'(1));
   assign stat.out_free   = !out_valid_ff || rsp_tready;

   always_comb begin
      slave_addr_in = slave_addr_ff;
      reg_count_in  = reg_count_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_SLAVE_ADDRESS:  slave_addr_in = csr_wdata;
            CSR_REGISTER_COUNT: reg_count_in  = csr_wdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      addr_in   = addr_ff;
      func_in   = func_ff;
      cnt_in    = cnt_ff;
      crc_lo_in = crc_lo_ff;
      code_in   = code_ff;
      rd_idx_in = rd_idx_ff;
      hi_we     = 1'b0;
      lo_we     = 1'b0;
      if (cmd.take_timeout) begin
         pos_in  = '0;
         crc_in  = CRC_INIT;
         code_in = STATUS_TIMEOUT;
      end else if (cmd.take_byte) begin
         if (pos_ff < len_m2) begin
            crc_in = crc16_byte(crc_ff, rx);
            pos_in = pos_ff + POS_W'(1);
            if (pos_ff == POS_ADDR) begin
               addr_in = rx;
            end else if (pos_ff == POS_FUNC) begin
               func_in = rx;
            end else if (pos_ff == POS_COUNT) begin
               cnt_in = rx;
            end else if (slot_ok) begin
               hi_we = ~off[0];
               lo_we = off[0];
            end
         end else if (pos_ff == len_m2) begin
            crc_lo_in = rx;
            pos_in    = pos_ff + POS_W'(1);
         end else begin
            pos_in    = '0;
            crc_in    = CRC_INIT;
            code_in   = verdict;
            rd_idx_in = '0;
         end
      end else if (cmd.rd_next) begin
         rd_idx_in = rd_idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      out_valid_in     = out_valid_ff;
      out_is_status_in = out_is_status_ff;
      out_idx_in       = out_idx_ff;
      out_val_in       = out_val_ff;
      out_status_in    = out_status_ff;
      out_last_in      = out_last_ff;
      if (cmd.emit_value) begin
         out_valid_in     = 1'b1;
         out_is_status_in = 1'b0;
         out_idx_in       = IDX_OUT_W'(rd_idx_ff);
         out_val_in       = {rd_hi_ff, rd_lo_ff};
         out_status_in    = STATUS_OK;
         out_last_in      = 1'b0;
      end else if (cmd.emit_status) begin
         out_valid_in     = 1'b1;
         out_is_status_in = 1'b1;
         out_idx_in       = '0;
         out_val_in       = '0;
         out_status_in    = code_ff;
         out_last_in      = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= SLAVE_ADDRESS_RST;
         reg_count_ff  <= REGISTER_COUNT_RST;
         pos_ff        <= '0;
         crc_ff        <= CRC_INIT;
         addr_ff       <= '0;
         func_ff       <= '0;
         cnt_ff        <= '0;
         crc_lo_ff     <= '0;
         code_ff       <= STATUS_OK;
         rd_idx_ff     <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         slave_addr_ff <= slave_addr_in;
         reg_count_ff  <= reg_count_in;
         pos_ff        <= pos_in;
         crc_ff        <= crc_in;
         addr_ff       <= addr_in;
         func_ff       <= func_in;
         cnt_ff        <= cnt_in;
         crc_lo_ff     <= crc_lo_in;
         code_ff       <= code_in;
         rd_idx_ff     <= rd_idx_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_is_status_ff <= out_is_status_in;
      out_idx_ff       <= out_idx_in;
      out_val_ff       <= out_val_in;
      out_status_ff    <= out_status_in;
      out_last_ff      <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (hi_we) begin
         buf_hi_ff[slot[IDX_W-1:0]] <= rx;
      end
      if (lo_we) begin
         buf_lo_ff[slot[IDX_W-1:0]] <= rx;
      end
      rd_hi_ff <= buf_hi_ff[rd_idx_ff];
      rd_lo_ff <= buf_lo_ff[rd_idx_ff];
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_is_status_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), out_status_ff, out_val_ff, out_idx_ff};

endmodule

// ===== rtl/core/mbrc_ctrl.sv =====
// Controller: accepts bytes and timeouts, then sequences the register drain and the closing status item.
module mbrc_ctrl
   import mbrc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_tuser,
   input  mbrc_stat_type stat,
   output mbrc_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_VALUE,
      ST_STATUS
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser) begin
                  cmd.take_timeout = 1'b1;
                  state_in         = ST_STATUS;
               end else begin
                  cmd.take_byte = 1'b1;
                  if (stat.final_byte) begin
                     state_in = stat.verdict_ok ? ST_FETCH : ST_STATUS;
                  end
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_VALUE;
         end
         ST_VALUE: begin
            if (stat.out_free) begin
               cmd.emit_value = 1'b1;
               if (stat.rd_last) begin
                  state_in = ST_STATUS;
               end else begin
                  cmd.rd_next = 1'b1;
                  state_in    = ST_FETCH;
               end
            end
         end
         ST_STATUS: begin
            if (stat.out_free) begin
               cmd.emit_status = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/modbus_read_response_checker.sv =====
// Top level of the read-input-registers reply checker: controller plus datapath.
// A non-final byte or a timeout is taken while the controller is idle; a non-final byte leaves the input open.
// A failed frame or a timeout moves to the status state, which loads its status item once the output is free.
// A good frame drains n register items, each by a buffer read (fetch state) then an output load (value state),
// then the status item; the input reopens once the status item is loaded into the output register.
// Synchronous active-high reset clears frame state and config to defaults; the buffer is kept.
module modbus_read_response_checker
   import mbrc_pkg::*;
#(
   parameter int MAX_REGISTERS = MAX_REGISTERS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // rx_byte[7:0]
   input  logic                  req_tuser,  // req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // reg_index[3:0], reg_value[19:4], status[21:20], pad
   output logic                  rsp_tuser,  // is_status
   output logic                  rsp_tlast
);

   mbrc_cmd_type  cmd;
   mbrc_stat_type stat;

   mbrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   mbrc_dp #(
      .MAX_REGISTERS (MAX_REGISTERS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/core/mbrc_checker.sv =====
// Port-level checks for the reply checker and their bind to the top level.
module mbrc_checker
   import mbrc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  rsp_tlast
);

   a_status_ends_frame : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("status item without tlast");

   a_value_item_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> !rsp_tlast && (rsp_tdata[21:20] == STATUS_OK))
      else $error("value item carries tlast or a status code");

   a_timeout_blocks_input : assert property (@(posedge clock) disable iff (reset)
      !reset && req_tvalid && req_tready && req_tuser |=> !req_tready)
      else $error("input reopened before timeout status item");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !reset && rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result item changed");

endmodule

bind modbus_read_response_checker mbrc_checker u_mbrc_checker (.*);

// ===== sim/mbrc_reply_scoreboard.sv =====
// Reply-checker scoreboard: watches csr writes and both streams, predicts every reply item and compares.
package mbrc_tb_pkg;
   import mbrc_pkg::*;

   localparam logic REQ_BYTE    = 1'b0;
   localparam logic REQ_TIMEOUT = 1'b1;

   typedef struct packed {
      logic                is_status;
      logic [IDX_OUT_W-1:0] reg_index;
      logic [VAL_W-1:0]    reg_value;
      logic [STATUS_W-1:0] status;
      logic                last;
   } reply_item_type;

   function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] data);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int k = 0; k < 8; k++) begin
         fb = r[0] ^ data[k];
         r  = {1'b0, r[15:1]};
         if (fb) r = r ^ CRC_POLY;
      end
      return r;
   endfunction

   function automatic reply_item_type make_item(input logic st, input int idx,
                                                input logic [VAL_W-1:0] val,
                                                input logic [STATUS_W-1:0] code,
                                                input logic lst);
      reply_item_type it;
      it.is_status = st;
      it.reg_index = idx[IDX_OUT_W-1:0];
      it.reg_value = val;
      it.status    = code;
      it.last      = lst;
      return it;
   endfunction
endpackage

module mbrc_reply_scoreboard
   import mbrc_pkg::*;
   import mbrc_tb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  rsp_tlast,
   output int                    failures,
   output int                    replies_due,
   output int                    replies_checked
);

   logic [7:0]       want_addr;
   logic [CNT_W-1:0] want_count;
   logic [4:0]       byte_pos;
   logic [15:0]      crc_acc;
   logic [7:0]       hdr_addr;
   logic [7:0]       hdr_func;
   logic [7:0]       hdr_bcnt;
   logic [7:0]       crc_lo;
   logic [15:0]      word_buf [MAX_REGISTERS_DEF];
   reply_item_type   expected_q[$];
   reply_item_type   got;
   reply_item_type   want;

   initial begin
      failures        = 0;
      replies_due     = 0;
      replies_checked = 0;
   end

   task automatic take_request(input logic kind, input logic [7:0] b);
      int          n;
      int          frame_len;
      int          slot;
      logic [15:0] recv;
      n = (want_count == 0) ? 1 :
          (want_count > MAX_REGISTERS_DEF) ? MAX_REGISTERS_DEF : int'(want_count);
      frame_len = HDR_LEN + 2 * n;
      if (kind == REQ_TIMEOUT) begin
         expected_q.push_back(make_item(1'b1, 0, '0, STATUS_TIMEOUT, 1'b1));
         byte_pos = '0;
         crc_acc  = CRC_INIT;
      end else if (int'(byte_pos) < frame_len - 2) begin
         crc_acc = crc_step(crc_acc, b);
         if (byte_pos == 0) hdr_addr = b;
         else if (byte_pos == 1) hdr_func = b;
         else if (byte_pos == 2) hdr_bcnt = b;
         else begin
            slot = (int'(byte_pos) - 3) / 2;
            if (slot < MAX_REGISTERS_DEF) begin
               if (byte_pos[0]) word_buf[slot][15:8] = b;
               else word_buf[slot][7:0] = b;
            end
         end
         byte_pos = byte_pos + 1'b1;
      end else if (int'(byte_pos) == frame_len - 2) begin
         crc_lo   = b;
         byte_pos = byte_pos + 1'b1;
      end else begin
         recv     = {b, crc_lo};
         byte_pos = '0;
         if (recv != crc_acc) begin
            expected_q.push_back(make_item(1'b1, 0, '0, STATUS_CRC, 1'b1));
         end else if ((hdr_func & FUNC_EXC_BIT) != 0 || hdr_addr != want_addr ||
                      hdr_func != FUNC_READ_INPUT || hdr_bcnt != 8'(2 * n)) begin
            expected_q.push_back(make_item(1'b1, 0, '0, STATUS_HDR, 1'b1));
         end else begin
            for (int i = 0; i < n; i++)
               expected_q.push_back(make_item(1'b0, i, word_buf[i], STATUS_OK, 1'b0));
            expected_q.push_back(make_item(1'b1, 0, '0, STATUS_OK, 1'b1));
         end
         crc_acc = CRC_INIT;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         want_addr  = SLAVE_ADDRESS_RST;
         want_count = REGISTER_COUNT_RST;
         byte_pos   = '0;
         crc_acc    = CRC_INIT;
         hdr_addr   = '0;
         hdr_func   = '0;
         hdr_bcnt   = '0;
         crc_lo     = '0;
         expected_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.is_status = rsp_tuser;
            got.reg_index = rsp_tdata[IDX_OUT_W-1:0];
            got.reg_value = rsp_tdata[IDX_OUT_W+VAL_W-1:IDX_OUT_W];
            got.status    = rsp_tdata[IDX_OUT_W+VAL_W+STATUS_W-1:IDX_OUT_W+VAL_W];
            got.last      = rsp_tlast;
            replies_checked++;
            if (expected_q.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("reply %0d unexpected: st=%0b idx=%0d val=%h code=%0d last=%0b",
                           replies_checked, got.is_status, got.reg_index, got.reg_value,
                           got.status, got.last);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  failures++;
                  if (failures <= 10)
                     $display("reply %0d mismatch: exp %0b/%0d/%h/%0d/%0b got %0b/%0d/%h/%0d/%0b",
                              replies_checked, want.is_status, want.reg_index, want.reg_value,
                              want.status, want.last, got.is_status, got.reg_index,
                              got.reg_value, got.status, got.last);
               end
            end
         end
         if (req_tvalid && req_tready) take_request(req_tuser, req_tdata);
         if (csr_we) begin
            case (csr_addr)
               CSR_SLAVE_ADDRESS:  want_addr = csr_wdata;
               CSR_REGISTER_COUNT: want_count = csr_wdata[CNT_W-1:0];
               default: ;
            endcase
         end
      end
      replies_due = expected_q.size();
   end

endmodule

// ===== sim/tb_modbus_read_response_checker.sv =====
// Testbench top for the read-input-registers reply checker: clock, reset, stimulus and verdict.
module tb_modbus_read_response_checker;
   import mbrc_pkg::*;
   import mbrc_tb_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_addr;
   logic [CFG_W-1:0]      csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   int failures;
   int replies_due;
   int replies_checked;

   logic [7:0]       cur_addr;
   logic [CNT_W-1:0] cur_count;
   int               items_sent;
   int               frames_sent;
   int               csr_writes;
   bit               no_idle;

   modbus_read_response_checker u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   mbrc_reply_scoreboard u_scoreboard (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .failures        (failures),
      .replies_due     (replies_due),
      .replies_checked (replies_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #6000000;
      $display("tb_modbus_read_response_checker: FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int eff_count();
      if (cur_count == 0) return 1;
      if (cur_count > MAX_REGISTERS_DEF) return MAX_REGISTERS_DEF;
      return int'(cur_count);
   endfunction

   initial begin
      int burst;
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         burst      = $urandom_range(1, 20);
         rsp_tready = 1'b1;
         repeat (burst - 1) @(negedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
      end
   end

   task automatic push_item(input logic kind, input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = b;
      do @(posedge clock); while (req_tready !== 1'b1);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid = 1'b0;
      do @(negedge clock); while (replies_due != 0);
      repeat (30) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      csr_writes++;
      if (idx == CSR_SLAVE_ADDRESS) cur_addr = val;
      else cur_count = val[CNT_W-1:0];
   endtask

   // cut < 0 sends the whole frame, otherwise cut bytes and then a timeout
   task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
                             input logic [7:0] bcnt, input logic [15:0] first_word,
                             input logic [15:0] crc_flip, input int cut);
      logic [7:0]  fr[$];
      logic [15:0] c;
      int          n;
      n = eff_count();
      fr.push_back(addr);
      fr.push_back(func);
      fr.push_back(bcnt);
      fr.push_back(first_word[15:8]);
      fr.push_back(first_word[7:0]);
      repeat (2 * n - 2) fr.push_back(8'($urandom));
      c = CRC_INIT;
      foreach (fr[i]) c = crc_step(c, fr[i]);
      c = c ^ crc_flip;
      fr.push_back(c[7:0]);
      fr.push_back(c[15:8]);
      if (cut < 0) begin
         foreach (fr[i]) push_item(REQ_BYTE, fr[i]);
      end else begin
         for (int i = 0; i < cut; i++) push_item(REQ_BYTE, fr[i]);
         push_item(REQ_TIMEOUT, 8'($urandom));
      end
      frames_sent++;
   endtask

   initial begin
      logic [7:0]  addr_list [4];
      logic [3:0]  count_list [6];
      logic [7:0]  hdr [5];
      logic [7:0]  f;
      logic [15:0] c;
      int          base;
      int          r;
      int          n;
      int          cfg_round;
      int          in_round;

      addr_list  = '{8'h00, 8'hFF, 8'h01, 8'hA5};
      count_list = '{4'd12, 4'd0, 4'd15, 4'd13, 4'd1, 4'd2};
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_addr    = '0;
      csr_wdata   = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = REQ_BYTE;
      cur_addr    = SLAVE_ADDRESS_RST;
      cur_count   = REGISTER_COUNT_RST;
      items_sent  = 0;
      frames_sent = 0;
      csr_writes  = 0;
      no_idle     = 1'b0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      push_item(REQ_TIMEOUT, 8'hFF);
      send_frame(cur_addr, FUNC_READ_INPUT, 8'd2, 16'h00FF, 16'h0000, -1);
      send_frame(cur_addr, FUNC_EXC_BIT | FUNC_READ_INPUT, 8'd2, 16'hFF00, 16'h0000, -1);
      send_frame(cur_addr, FUNC_READ_INPUT, 8'd2, 16'h5AA5, 16'h0000, 2);

      // shrink the frame while it is in flight; the new length ends it early
      wait_idle();
      csr_write(CSR_SLAVE_ADDRESS, 8'hFF);
      csr_write(CSR_REGISTER_COUNT, 8'h0F);
      hdr = '{8'hFF, FUNC_READ_INPUT, 8'd2, 8'h12, 8'h34};
      c = CRC_INIT;
      foreach (hdr[i]) begin
         c = crc_step(c, hdr[i]);
         push_item(REQ_BYTE, hdr[i]);
      end
      wait_idle();
      csr_write(CSR_REGISTER_COUNT, 8'hF0);
      push_item(REQ_BYTE, c[7:0]);
      push_item(REQ_BYTE, c[15:8]);
      frames_sent++;

      base      = items_sent;
      cfg_round = 0;
      in_round  = 3;
      while (items_sent - base < 335) begin
         if (in_round >= 3) begin
            wait_idle();
            if (cfg_round < 4) csr_write(CSR_SLAVE_ADDRESS, addr_list[cfg_round]);
            else csr_write(CSR_SLAVE_ADDRESS, 8'($urandom));
            if (cfg_round < 6) csr_write(CSR_REGISTER_COUNT, {4'($urandom), count_list[cfg_round]});
            else csr_write(CSR_REGISTER_COUNT, 8'($urandom));
            cfg_round++;
            in_round = 0;
         end
         in_round++;
         if ($urandom_range(0, 7) == 0) no_idle = ~no_idle;
         n = eff_count();
         r = $urandom_range(0, 99);
         if (r < 55) begin
            send_frame(cur_addr, FUNC_READ_INPUT, 8'(2 * n), 16'($urandom), 16'h0000, -1);
         end else if (r < 63) begin
            send_frame(cur_addr ^ 8'($urandom_range(1, 255)), FUNC_READ_INPUT, 8'(2 * n),
                       16'($urandom), 16'h0000, -1);
         end else if (r < 70) begin
            send_frame(cur_addr, FUNC_EXC_BIT | 8'($urandom_range(0, 127)), 8'(2 * n),
                       16'($urandom), 16'h0000, -1);
         end else if (r < 76) begin
            f = 8'($urandom_range(0, 127));
            if (f == FUNC_READ_INPUT) f = 8'h03;
            send_frame(cur_addr, f, 8'(2 * n), 16'($urandom), 16'h0000, -1);
         end else if (r < 82) begin
            send_frame(cur_addr, FUNC_READ_INPUT, 8'(2 * n) ^ 8'($urandom_range(1, 255)),
                       16'($urandom), 16'h0000, -1);
         end else if (r < 90) begin
            send_frame(cur_addr, FUNC_READ_INPUT, 8'(2 * n), 16'($urandom),
                       16'($urandom_range(1, 65535)), -1);
         end else begin
            send_frame(cur_addr, FUNC_READ_INPUT, 8'(2 * n), 16'($urandom), 16'h0000,
                       $urandom_range(0, 4 + 2 * n));
         end
      end

      req_tvalid = 1'b0;
      do @(negedge clock); while (replies_due != 0);
      repeat (40) @(negedge clock);
      $display("covered %0d request items in %0d frames, %0d csr writes, %0d replies checked",
               items_sent, frames_sent, csr_writes, replies_checked);
      $display("frames: good, bad crc, exception, header mismatch, timeout cut, resized in flight");
      if (failures == 0 && replies_due == 0) begin
         $display("tb_modbus_read_response_checker: PASS");
      end else begin
         $display("tb_modbus_read_response_checker: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/mbrc_pkg.sv
rtl/core/mbrc_dp.sv
rtl/core/mbrc_ctrl.sv
rtl/core/modbus_read_response_checker.sv
rtl/core/mbrc_checker.sv
sim/mbrc_reply_scoreboard.sv
sim/tb_modbus_read_response_checker.sv
